/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet decode for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CharW      = 21;
  localparam int ByteW      = 8;
  localparam int DigitW     = 6;
  localparam int AccW       = 3 * DigitW;   // three pending digits at most
  localparam int GroupW     = 3 * ByteW;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic       OpChar    = 1'b0;
  localparam logic       OpRestart = 1'b1;

  localparam logic [6:0] CharPad   = 7'h3D;
  localparam logic [6:0] CharPlus  = 7'h2B;
  localparam logic [6:0] CharSlash = 7'h2F;
  localparam logic [5:0] DigitPlus  = 6'd62;
  localparam logic [5:0] DigitSlash = 6'd63;

  // One group of decoded bytes, first byte in the top lane.
  typedef struct packed {
    logic [GroupW-1:0] data;
    logic [1:0]        nbytes;   // 1..3
    logic              pad;      // produced by the padding character
  } b64d_grp_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  typedef struct packed {
    logic             ok;
    logic [DigitW-1:0] value;
  } b64d_digit_t;

  // Alphabet lookup of a 7-bit character.
  function automatic b64d_digit_t digit_of(logic [6:0] c);
    b64d_digit_t d;
    d = '0;
    case (c) inside
      [7'h41:7'h5A]: begin
        d.ok    = 1'b1;
        d.value = 6'(c - 7'h41);
      end
      [7'h61:7'h7A]: begin
        d.ok    = 1'b1;
        d.value = 6'(c - 7'h61 + 7'd26);
      end
      [7'h30:7'h39]: begin
        d.ok    = 1'b1;
        d.value = 6'(c - 7'h30 + 7'd52);
      end
      CharPlus: begin
        d.ok    = 1'b1;
        d.value = DigitPlus;
      end
      CharSlash: begin
        d.ok    = 1'b1;
        d.value = DigitSlash;
      end
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/b64d_if.sv */
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready channels for character requests and decoded byte requests.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [b64d_pkg::CharW-1:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface b64d_out_if;
  logic                       valid;
  logic                       ready;
  logic [b64d_pkg::ByteW-1:0] data_byte;
  logic                       last_of_run;
  logic                       end_of_data;

  modport source (output valid, output data_byte, output last_of_run,
                  output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input last_of_run,
                  input end_of_data, output ready);
endinterface

/* rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, decodes digits, packs groups and pushes them on.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [b64d_pkg::CharW-1:0] in_char,
  input  b64d_pkg::b64d_qstat_t q_stat,
  output logic                  push,
  output b64d_pkg::b64d_grp_t   push_grp
);

  logic [b64d_pkg::AccW-1:0] acc_r, acc_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic                      ended_r, ended_nxt;

  logic                  accept;
  logic                  ascii;
  logic                  is_pad;
  b64d_pkg::b64d_digit_t dig;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign ascii    = (in_char[b64d_pkg::CharW-1:7] == '0);
  assign is_pad   = (in_char[6:0] == b64d_pkg::CharPad);
  assign dig      = b64d_pkg::digit_of(in_char[6:0]);

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    push      = 1'b0;
    push_grp  = '0;
    if (accept) begin
      if (in_op == b64d_pkg::OpRestart) begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        ended_nxt = 1'b0;
      end else if (!ended_r && ascii) begin
        if (is_pad) begin
          // pad flushes the partial group and closes the stream
          if (cnt_r == 2'd2) begin
            push            = 1'b1;
            push_grp.data   = {acc_r[11:4], 16'h0000};
            push_grp.nbytes = 2'd1;
            push_grp.pad    = 1'b1;
          end else if (cnt_r == 2'd3) begin
            push            = 1'b1;
            push_grp.data   = {acc_r[17:10], acc_r[9:2], 8'h00};
            push_grp.nbytes = 2'd2;
            push_grp.pad    = 1'b1;
          end
          acc_nxt   = '0;
          cnt_nxt   = '0;
          ended_nxt = 1'b1;
        end else if (dig.ok) begin
          if (cnt_r == 2'd3) begin
            push            = 1'b1;
            push_grp.data   = {acc_r, dig.value};
            push_grp.nbytes = 2'd3;
            push_grp.pad    = 1'b0;
            acc_nxt         = '0;
            cnt_nxt         = '0;
          end else begin
            acc_nxt = {acc_r[b64d_pkg::AccW-b64d_pkg::DigitW-1:0], dig.value};
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      ended_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

/* rtl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Short register FIFO of byte groups between front and back.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64d_pkg::b64d_grp_t   push_grp,
  input  logic                  pop,
  output b64d_pkg::b64d_grp_t   head_grp,
  output b64d_pkg::b64d_qstat_t q_stat
);

  b64d_pkg::b64d_grp_t mem_r [b64d_pkg::QueueDepth];

  logic [b64d_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [b64d_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [b64d_pkg::QCntW-1:0] cnt_r, cnt_nxt;

  logic do_push, do_pop;

  assign q_stat.full  = (cnt_r == b64d_pkg::QCntW'(b64d_pkg::QueueDepth));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_grp     = mem_r[rd_ptr_r];

  function automatic logic [b64d_pkg::QPtrW-1:0] ptr_inc(
      logic [b64d_pkg::QPtrW-1:0] p);
    logic [b64d_pkg::QPtrW-1:0] n;
    if (p == b64d_pkg::QPtrW'(b64d_pkg::QueueDepth - 1)) n = '0;
    else                                                 n = p + 1'b1;
    return n;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Splits queued groups into bytes and drives the registered output.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  b64d_pkg::b64d_grp_t        head_grp,
  input  b64d_pkg::b64d_qstat_t      q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [b64d_pkg::ByteW-1:0] out_byte,
  output logic                       out_last,
  output logic                       out_pad
);

  logic [1:0]                idx_r, idx_nxt;
  logic                      vld_r, vld_nxt;
  logic [b64d_pkg::ByteW-1:0] byte_r, byte_nxt;
  logic                      last_r, last_nxt;
  logic                      pad_r, pad_nxt;

  logic load;
  logic is_last;
  logic [b64d_pkg::ByteW-1:0] sel_byte;

  assign load    = !q_stat.empty && (!vld_r || out_ready);
  assign is_last = ((idx_r + 2'd1) == head_grp.nbytes);
  assign pop     = load && is_last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head_grp.data[23:16];
      2'd1:    sel_byte = head_grp.data[15:8];
      default: sel_byte = head_grp.data[7:0];
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    pad_nxt  = pad_r;
    if (load) begin
      vld_nxt  = 1'b1;
      byte_nxt = sel_byte;
      last_nxt = is_last;
      pad_nxt  = head_grp.pad;
      idx_nxt  = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    pad_r  <= pad_nxt;
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_pad   = pad_r;

endmodule

/* rtl/base64_char_decoder.sv */
// ----------------------------------------------------------------------------
// base64_char_decoder
// Standard base64 decoder: one character request in, decoded byte requests out.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                               request done when
//  -------   ---  ------------------------------------  ----------------------
//  in_ch     in   op, char_code                         valid && ready
//  out_ch    out  data_byte, last_of_run, end_of_data   valid && ready
//
// Takes one character per cycle unless the group queue is full; the front
// decodes and packs in the same cycle it accepts, so a full group is queued
// in the cycle after its 4th digit. The back sends one byte per cycle, unless
// out_ch stalls, from a registered output that is loaded from the queue head.
// in_ch.ready drops only while the two-entry group queue is full.
// Synchronous active-low reset clears digits, end flag, queue and output.
//
module base64_char_decoder (
  input logic            clk,
  input logic            rst_n,
  b64d_in_if.sink        in_ch,
  b64d_out_if.source     out_ch
);

  b64d_pkg::b64d_grp_t   push_grp;
  b64d_pkg::b64d_grp_t   head_grp;
  b64d_pkg::b64d_qstat_t q_stat;
  logic                  push;
  logic                  pop;

  // Front: alphabet lookup, digit accumulation, pad handling.
  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_op    (in_ch.op),
    .in_char  (in_ch.char_code),
    .q_stat   (q_stat),
    .push     (push),
    .push_grp (push_grp)
  );

  // Group queue decouples character intake from byte output.
  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .q_stat   (q_stat)
  );

  // Back: serializes each group into bytes, flags last and pad.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_grp  (head_grp),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.data_byte),
    .out_last  (out_ch.last_of_run),
    .out_pad   (out_ch.end_of_data)
  );

endmodule
